/* rtl/tsp_pkg.sv */
// tsp_pkg: shared types, constants and the fixed note tables of the tone sequence player
// used by tsp_ctrl, tsp_scale and the top level; no dependencies
package tsp_pkg;

    localparam int THEMES    = 3;
    localparam int SOUNDS    = 5;
    localparam int MAX_NOTES = 7;

    localparam int THEME_W = 2;
    localparam int SOUND_W = 3;
    localparam int INDEX_W = 3;
    localparam int HZ_W    = 11;
    localparam int MS_W    = 9;
    localparam int AMP_W   = 8;
    localparam int VOL_W   = 7;
    localparam int PROD_W  = AMP_W + VOL_W;

    localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

    // floor(p / 100) == (p * 5243) >> 19 for every p below 2^15
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 19;
    localparam logic [RECIP_W-1:0] AMP_RECIP = 13'd5243;

    typedef enum logic [1:0] {
        OP_STOP = 2'd0,
        OP_PLAY = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [HZ_W-1:0]  hz;
        logic [MS_W-1:0]  ms;
        logic [AMP_W-1:0] amp;
    } t_tone;

    typedef struct packed {
        logic              note_valid;
        logic [HZ_W-1:0]   hz;
        logic [MS_W-1:0]   ms;
        logic [PROD_W-1:0] prod;
        logic              playing;
    } t_stage;

    function automatic logic [INDEX_W-1:0] seq_len(input logic [THEME_W-1:0] th,
                                                   input logic [SOUND_W-1:0] snd);
        logic [INDEX_W-1:0] n;
        unique case ({th, snd})
            {2'd0, 3'd0}: n = 3'd3;
            {2'd0, 3'd1}: n = 3'd6;
            {2'd0, 3'd2}: n = 3'd3;
            {2'd0, 3'd3}: n = 3'd1;
            {2'd0, 3'd4}: n = 3'd1;
            {2'd1, 3'd0}: n = 3'd4;
            {2'd1, 3'd1}: n = 3'd7;
            {2'd1, 3'd2}: n = 3'd3;
            {2'd1, 3'd3}: n = 3'd1;
            {2'd1, 3'd4}: n = 3'd1;
            {2'd2, 3'd0}: n = 3'd2;
            {2'd2, 3'd1}: n = 3'd6;
            {2'd2, 3'd2}: n = 3'd2;
            {2'd2, 3'd3}: n = 3'd1;
            {2'd2, 3'd4}: n = 3'd1;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_tone seq_tone(input logic [THEME_W-1:0] th,
                                       input logic [SOUND_W-1:0] snd,
                                       input logic [INDEX_W-1:0] idx);
        t_tone t;
        unique case ({th, snd, idx})
            {2'd0, 3'd0, 3'd0}: t = '{11'd660,  9'd90,  8'd150};
            {2'd0, 3'd0, 3'd1}: t = '{11'd990,  9'd90,  8'd150};
            {2'd0, 3'd0, 3'd2}: t = '{11'd1320, 9'd140, 8'd140};
            {2'd0, 3'd1, 3'd0}: t = '{11'd1320, 9'd120, 8'd200};
            {2'd0, 3'd1, 3'd1}: t = '{11'd990,  9'd120, 8'd200};
            {2'd0, 3'd1, 3'd2}: t = '{11'd1320, 9'd120, 8'd200};
            {2'd0, 3'd1, 3'd3}: t = '{11'd990,  9'd120, 8'd200};
            {2'd0, 3'd1, 3'd4}: t = '{11'd1320, 9'd200, 8'd190};
            {2'd0, 3'd1, 3'd5}: t = '{11'd1320, 9'd120, 8'd110};
            {2'd0, 3'd2, 3'd0}: t = '{11'd990,  9'd120, 8'd140};
            {2'd0, 3'd2, 3'd1}: t = '{11'd660,  9'd180, 8'd120};
            {2'd0, 3'd2, 3'd2}: t = '{11'd660,  9'd120, 8'd70};
            {2'd0, 3'd3, 3'd0}: t = '{11'd1760, 9'd40,  8'd40};
            {2'd0, 3'd4, 3'd0}: t = '{11'd1320, 9'd40,  8'd55};
            {2'd1, 3'd0, 3'd0}: t = '{11'd523,  9'd70,  8'd170};
            {2'd1, 3'd0, 3'd1}: t = '{11'd659,  9'd70,  8'd170};
            {2'd1, 3'd0, 3'd2}: t = '{11'd784,  9'd70,  8'd170};
            {2'd1, 3'd0, 3'd3}: t = '{11'd1047, 9'd140, 8'd190};
            {2'd1, 3'd1, 3'd0}: t = '{11'd1047, 9'd100, 8'd200};
            {2'd1, 3'd1, 3'd1}: t = '{11'd784,  9'd100, 8'd200};
            {2'd1, 3'd1, 3'd2}: t = '{11'd1047, 9'd100, 8'd200};
            {2'd1, 3'd1, 3'd3}: t = '{11'd1319, 9'd200, 8'd215};
            {2'd1, 3'd1, 3'd4}: t = '{11'd0,    9'd60,  8'd0};
            {2'd1, 3'd1, 3'd5}: t = '{11'd1319, 9'd100, 8'd200};
            {2'd1, 3'd1, 3'd6}: t = '{11'd1568, 9'd220, 8'd215};
            {2'd1, 3'd2, 3'd0}: t = '{11'd784,  9'd80,  8'd150};
            {2'd1, 3'd2, 3'd1}: t = '{11'd1047, 9'd80,  8'd150};
            {2'd1, 3'd2, 3'd2}: t = '{11'd784,  9'd160, 8'd120};
            {2'd1, 3'd3, 3'd0}: t = '{11'd1047, 9'd40,  8'd45};
            {2'd1, 3'd4, 3'd0}: t = '{11'd880,  9'd40,  8'd60};
            {2'd2, 3'd0, 3'd0}: t = '{11'd880,  9'd120, 8'd130};
            {2'd2, 3'd0, 3'd1}: t = '{11'd660,  9'd200, 8'd110};
            {2'd2, 3'd1, 3'd0}: t = '{11'd880,  9'd180, 8'd180};
            {2'd2, 3'd1, 3'd1}: t = '{11'd0,    9'd80,  8'd0};
            {2'd2, 3'd1, 3'd2}: t = '{11'd880,  9'd180, 8'd180};
            {2'd2, 3'd1, 3'd3}: t = '{11'd0,    9'd80,  8'd0};
            {2'd2, 3'd1, 3'd4}: t = '{11'd660,  9'd320, 8'd170};
            {2'd2, 3'd1, 3'd5}: t = '{11'd660,  9'd160, 8'd90};
            {2'd2, 3'd2, 3'd0}: t = '{11'd660,  9'd160, 8'd110};
            {2'd2, 3'd2, 3'd1}: t = '{11'd880,  9'd240, 8'd100};
            {2'd2, 3'd3, 3'd0}: t = '{11'd880,  9'd40,  8'd30};
            {2'd2, 3'd4, 3'd0}: t = '{11'd660,  9'd40,  8'd45};
            default:            t = '{11'd0,    9'd0,   8'd0};
        endcase
        return t;
    endfunction

endpackage

/* rtl/tsp_ctrl.sv */
// tsp_ctrl: player state, opcode decode, note table read and amplitude product
// depends on tsp_pkg
module tsp_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic                    i_in_valid,
    input  logic [1:0]              i_opcode,
    input  logic [7:0]              i_theme,
    input  logic [2:0]              i_sound_id,
    input  logic [7:0]              i_volume,
    input  logic [31:0]             i_now_ms,
    output logic                    o_valid,
    output tsp_pkg::t_stage         o_stage
);

    logic                               r_active, n_active;
    logic [tsp_pkg::THEME_W-1:0]        r_theme, n_theme;
    logic [tsp_pkg::SOUND_W-1:0]        r_sound, n_sound;
    logic [tsp_pkg::INDEX_W-1:0]        r_count, n_count;
    logic [tsp_pkg::INDEX_W-1:0]        r_index, n_index;
    logic [31:0]                        r_due, n_due;
    logic [tsp_pkg::VOL_W-1:0]          r_vol, n_vol;
    logic                               r_valid;
    tsp_pkg::t_stage                    r_stage, n_stage;

    logic                               accept;
    logic [31:0]                        diff;
    tsp_pkg::t_tone                     tone;
    logic [tsp_pkg::THEME_W-1:0]        play_theme;
    logic [tsp_pkg::VOL_W-1:0]          play_vol;
    logic [tsp_pkg::INDEX_W-1:0]        play_len;

    assign accept = i_load && i_in_valid;
    assign diff   = i_now_ms - r_due;
    assign tone   = tsp_pkg::seq_tone(r_theme, r_sound, r_index);

    assign play_theme = (i_theme < 8'(tsp_pkg::THEMES)) ? i_theme[tsp_pkg::THEME_W-1:0]
                                                        : '0;
    assign play_vol   = (i_volume > {1'b0, tsp_pkg::VOL_MAX}) ? tsp_pkg::VOL_MAX
                                                              : i_volume[tsp_pkg::VOL_W-1:0];
    assign play_len   = tsp_pkg::seq_len(play_theme, i_sound_id);

    always_comb begin
        n_active = r_active;
        n_theme  = r_theme;
        n_sound  = r_sound;
        n_count  = r_count;
        n_index  = r_index;
        n_due    = r_due;
        n_vol    = r_vol;
        n_stage  = '0;
        unique case (tsp_pkg::t_opcode'(i_opcode))
            tsp_pkg::OP_STOP: begin
                n_active = 1'b0;
                n_theme  = '0;
                n_sound  = '0;
                n_count  = '0;
                n_index  = '0;
                n_due    = '0;
                n_vol    = '0;
            end
            tsp_pkg::OP_PLAY: begin
                n_active = 1'b0;
                n_theme  = '0;
                n_sound  = '0;
                n_count  = '0;
                n_index  = '0;
                n_due    = '0;
                n_vol    = '0;
                if (i_volume != 8'd0 && {1'b0, i_sound_id} < 4'(tsp_pkg::SOUNDS)
                        && play_len != '0) begin
                    n_active = 1'b1;
                    n_theme  = play_theme;
                    n_sound  = i_sound_id;
                    n_count  = play_len;
                    n_due    = i_now_ms;
                    n_vol    = play_vol;
                end
            end
            tsp_pkg::OP_TICK: begin
                if (r_active && !diff[31]) begin
                    if (r_index >= r_count || r_index >= 3'(tsp_pkg::MAX_NOTES)) begin
                        n_active = 1'b0;
                    end else begin
                        n_stage.note_valid = 1'b1;
                        n_stage.hz         = tone.hz;
                        n_stage.ms         = tone.ms;
                        n_stage.prod       = tone.amp * r_vol;
                        n_due              = i_now_ms + 32'(tone.ms);
                        n_index            = r_index + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_stage.playing = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_theme  <= '0;
            r_sound  <= '0;
            r_count  <= '0;
            r_index  <= '0;
            r_due    <= '0;
            r_vol    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_active <= n_active;
                r_theme  <= n_theme;
                r_sound  <= n_sound;
                r_count  <= n_count;
                r_index  <= n_index;
                r_due    <= n_due;
                r_vol    <= n_vol;
            end
            if (i_load) begin
                r_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* rtl/tsp_scale.sv */
// tsp_scale: divides the amplitude product by 100 and holds the result register
// depends on tsp_pkg
module tsp_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_valid,
    input  tsp_pkg::t_stage              i_stage,
    output logic                         o_valid,
    output logic                         o_note_valid,
    output logic [tsp_pkg::HZ_W-1:0]     o_note_hz,
    output logic [tsp_pkg::MS_W-1:0]     o_note_ms,
    output logic [tsp_pkg::AMP_W-1:0]    o_note_amp,
    output logic                         o_playing
);

    localparam int MUL_W = tsp_pkg::PROD_W + tsp_pkg::RECIP_W;

    logic                          r_valid;
    logic                          r_note_valid;
    logic [tsp_pkg::HZ_W-1:0]      r_hz;
    logic [tsp_pkg::MS_W-1:0]      r_ms;
    logic [tsp_pkg::AMP_W-1:0]     r_amp, n_amp;
    logic                          r_playing;
    logic [MUL_W-1:0]              scaled;

    // reciprocal multiply stands in for the divide by 100
    assign scaled = MUL_W'(i_stage.prod) * MUL_W'(tsp_pkg::AMP_RECIP);
    assign n_amp  = scaled[tsp_pkg::RECIP_SH +: tsp_pkg::AMP_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_note_valid <= i_stage.note_valid;
            r_hz         <= i_stage.hz;
            r_ms         <= i_stage.ms;
            r_amp        <= n_amp;
            r_playing    <= i_stage.playing;
        end
    end

    assign o_valid      = r_valid;
    assign o_note_valid = r_note_valid;
    assign o_note_hz    = r_hz;
    assign o_note_ms    = r_ms;
    assign o_note_amp   = r_amp;
    assign o_playing    = r_playing;

endmodule

/* rtl/tone_sequence_player.sv */
// tone_sequence_player: top level, joins the control stage and the scaling stage
// depends on tsp_pkg, tsp_ctrl, tsp_scale
//
// Takes one item per clock (stop, play or tick) while o_in_ready is high and returns exactly one result per item.
// The result reaches the output through two registers after the input item is accepted:
// the first holds the updated player state, the table note and the amplitude times volume
// product; the second holds the product divided by 100.
// The two stages form an elastic pipeline, so items keep flowing while a result waits and
// o_in_ready drops only when both stages hold items the output side has not taken.
module tone_sequence_player (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [7:0]                 i_theme,
    input  logic [2:0]                 i_sound_id,
    input  logic [7:0]                 i_volume,
    input  logic [31:0]                i_now_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_note_valid,
    output logic [10:0]                o_note_hz,
    output logic [8:0]                 o_note_ms,
    output logic [7:0]                 o_note_amp,
    output logic                       o_playing
);

    logic            a_valid;
    logic            a_load;
    logic            b_load;
    tsp_pkg::t_stage a_stage;

    assign b_load     = !o_out_valid || i_out_ready;
    assign a_load     = !a_valid || b_load;
    assign o_in_ready = a_load;

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (a_load),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_theme    (i_theme),
        .i_sound_id (i_sound_id),
        .i_volume   (i_volume),
        .i_now_ms   (i_now_ms),
        .o_valid    (a_valid),
        .o_stage    (a_stage)
    );

    tsp_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (b_load),
        .i_valid      (a_valid),
        .i_stage      (a_stage),
        .o_valid      (o_out_valid),
        .o_note_valid (o_note_valid),
        .o_note_hz    (o_note_hz),
        .o_note_ms    (o_note_ms),
        .o_note_amp   (o_note_amp),
        .o_playing    (o_playing)
    );

endmodule

/* rtl/tsp_checker.sv */
// tsp_checker: port level checks of the tone sequence player, bound to the top level
// depends on tone_sequence_player
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_note_valid,
    input logic [10:0] o_note_hz,
    input logic [8:0]  o_note_ms,
    input logic [7:0]  o_note_amp,
    input logic        o_playing
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_note_valid)
            && $stable(o_note_hz) && $stable(o_note_ms) && $stable(o_note_amp)
            && $stable(o_playing))
        else $error("result changed while stalled");

    // an empty output side never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_note_valid |-> o_note_hz == 11'd0 && o_note_ms == 9'd0
            && o_note_amp == 8'd0)
        else $error("fields set without a note");

    a_note_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_note_valid |-> o_playing && o_note_ms != 9'd0
            && o_note_amp <= 8'd215)
        else $error("note emitted outside play or amplitude out of range");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_note_valid (o_note_valid),
    .o_note_hz    (o_note_hz),
    .o_note_ms    (o_note_ms),
    .o_note_amp   (o_note_amp),
    .o_playing    (o_playing)
);
